// ----- hdl/scp_pkg.sv -----
// Shared types and character constants for the servo command parser.
package scp_pkg;

  // ASCII codes the parser looks for
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] GRIPPER_INDEX = 3'd5;
  localparam int         SERVO_ACC_W   = 8;
  localparam int         ANGLE_OUT_W   = 16;

  // Decoded view of one incoming byte
  typedef struct packed {
    logic       is_digit;
    logic       is_colon;
    logic       is_o;
    logic       is_c;
    logic [3:0] digit;
  } char_class_t;

  // Servo number scan phases
  typedef enum logic [2:0] {
    SP_SCAN   = 3'b001,
    SP_DIGITS = 3'b010,
    SP_DONE   = 3'b100
  } servo_phase_t;

  // Angle scan phases
  typedef enum logic [3:0] {
    AP_WAIT   = 4'b0001,
    AP_FIRST  = 4'b0010,
    AP_DIGITS = 4'b0100,
    AP_DONE   = 4'b1000
  } angle_phase_t;

  // One result item
  typedef struct packed {
    logic [2:0]             servo_index;
    logic                   servo_ok;
    logic [ANGLE_OUT_W-1:0] angle_value;
    logic                   angle_ok;
  } result_t;

endpackage

// ----- hdl/scp_servo.sv -----
// Servo number scanner: accumulates the decimal servo number of a message.
module scp_servo import scp_pkg::*; #(
  parameter int SERVO_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        last,
  input  logic        gripper,
  input  char_class_t cls,
  output logic        servo_ok,
  output logic [2:0]  servo_index
);

  servo_phase_t           phase, phase_next;
  logic [SERVO_ACC_W-1:0] accum, accum_next;
  logic                   seen, seen_next;
  logic [SERVO_ACC_W+3:0] push_sum;
  logic [SERVO_ACC_W-1:0] push_sat;
  logic [SERVO_ACC_W-1:0] upd_accum;
  logic [SERVO_ACC_W-1:0] idx_full;

  // accum * 10 + digit, saturating at all ones
  assign push_sum = ({4'b0, accum} << 3) + ({4'b0, accum} << 1)
                  + {{SERVO_ACC_W{1'b0}}, cls.digit};
  assign push_sat = (push_sum[SERVO_ACC_W+3:SERVO_ACC_W] != 4'b0) ?
                    {SERVO_ACC_W{1'b1}} : push_sum[SERVO_ACC_W-1:0];

  // Scan update for the byte being taken
  always_comb begin
    phase_next = phase;
    upd_accum  = accum;
    seen_next  = seen;
    if (step && !gripper) begin
      case (phase)
        SP_SCAN: begin
          if (cls.is_digit) begin
            upd_accum  = {{(SERVO_ACC_W-4){1'b0}}, cls.digit};
            seen_next  = 1'b1;
            phase_next = SP_DIGITS;
          end else if (cls.is_colon) begin
            phase_next = SP_DONE;
          end
        end
        SP_DIGITS: begin
          if (cls.is_digit) begin
            upd_accum = push_sat;
          end else begin
            phase_next = SP_DONE;
          end
        end
        default: ;
      endcase
    end
    accum_next = upd_accum;
  end

  // Result view: number must be 1..SERVO_COUNT
  assign idx_full    = upd_accum - SERVO_ACC_W'(1);
  assign servo_ok    = seen_next && (upd_accum != '0) &&
                       (upd_accum <= SERVO_ACC_W'(SERVO_COUNT));
  assign servo_index = servo_ok ? idx_full[2:0] : 3'd0;

  // State registers, cleared after the last byte of a message
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase <= SP_SCAN;
      accum <= '0;
      seen  <= 1'b0;
    end else begin
      phase <= phase_next;
      accum <= accum_next;
      seen  <= seen_next;
    end
  end

endmodule

// ----- hdl/scp_angle.sv -----
// Angle scanner: decodes the digits or gripper letter after the first colon.
module scp_angle import scp_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   last,
  input  logic                   gripper,
  input  char_class_t            cls,
  output logic                   angle_ok,
  output logic [ANGLE_OUT_W-1:0] angle_value
);

  angle_phase_t                     phase, phase_next;
  logic [ANGLE_WIDTH-1:0]           accum, accum_next;
  logic                             vflag, vflag_next;
  logic [ANGLE_WIDTH+3:0]           push_sum;
  logic [ANGLE_WIDTH-1:0]           push_sat;
  logic [ANGLE_WIDTH+ANGLE_OUT_W-1:0] accum_ext;

  // accum * 10 + digit, saturating at all ones
  assign push_sum = ({4'b0, accum} << 3) + ({4'b0, accum} << 1)
                  + {{ANGLE_WIDTH{1'b0}}, cls.digit};
  assign push_sat = (push_sum[ANGLE_WIDTH+3:ANGLE_WIDTH] != 4'b0) ?
                    {ANGLE_WIDTH{1'b1}} : push_sum[ANGLE_WIDTH-1:0];

  // Scan update for the byte being taken
  always_comb begin
    phase_next = phase;
    accum_next = accum;
    vflag_next = vflag;
    if (step) begin
      case (phase)
        AP_WAIT: begin
          if (cls.is_colon) phase_next = AP_FIRST;
        end
        AP_FIRST: begin
          if (gripper && cls.is_o) begin
            accum_next = '0;
            vflag_next = 1'b1;
            phase_next = AP_DONE;
          end else if (gripper && cls.is_c) begin
            accum_next = ANGLE_WIDTH'(1);
            vflag_next = 1'b1;
            phase_next = AP_DONE;
          end else if (cls.is_digit) begin
            accum_next = {{(ANGLE_WIDTH-4){1'b0}}, cls.digit};
            vflag_next = 1'b1;
            phase_next = AP_DIGITS;
          end else begin
            phase_next = AP_DONE;
          end
        end
        AP_DIGITS: begin
          if (cls.is_digit) begin
            accum_next = push_sat;
          end else begin
            phase_next = AP_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Result view, truncated or zero-extended to the output width
  assign accum_ext   = {{ANGLE_OUT_W{1'b0}}, accum_next};
  assign angle_ok    = vflag_next;
  assign angle_value = vflag_next ? accum_ext[ANGLE_OUT_W-1:0] : '0;

  // State registers, cleared after the last byte of a message
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase <= AP_WAIT;
      accum <= '0;
      vflag <= 1'b0;
    end else begin
      phase <= phase_next;
      accum <= accum_next;
      vflag <= vflag_next;
    end
  end

endmodule

// ----- hdl/scp_outbuf.sv -----
// Result register with a skid stage so the input side keeps moving.
module scp_outbuf import scp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    room,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_data
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  assign room      = !skid_valid;
  assign res_valid = out_valid;
  assign res_data  = out_data;

  // Control: output slot refills from skid first, else from a new item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || res_ready) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || res_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output slot is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed while skid stage is full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && res_ready) |=>
      (out_valid && !skid_valid && out_data == $past(skid_data)))
    else $error("skid item not moved into output slot");
`endif

endmodule

// ----- hdl/servo_command_parser_top.sv -----
// Top level of the servo command parser: byte classification and result assembly.
//
//  channel | signals                                   | dir | item
//  --------+-------------------------------------------+-----+---------------------
//  cmd     | cmd_valid, cmd_ready, char_byte, last_byte | in  | one message byte
//  res     | res_valid, res_ready, servo_index,        | out | one decoded command
//          | servo_ok, angle_value, angle_ok           |     |
//
//  One byte is taken per cycle while cmd_ready is high and updates the scan
//  registers in the cycle it is accepted. A last byte's result is registered
//  in the result register, or in the one-item skid stage while a result
//  waits, so bytes keep flowing; cmd_ready drops only when both are full.
//  Reset (rst, synchronous) returns all scanners to the start of a message.
module servo_command_parser_top import scp_pkg::*; #(
  parameter int ANGLE_WIDTH = 16,
  parameter int SERVO_COUNT = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  logic [7:0]             char_byte,
  input  logic                   last_byte,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [2:0]             servo_index,
  output logic                   servo_ok,
  output logic [ANGLE_OUT_W-1:0] angle_value,
  output logic                   angle_ok
);

  logic                   step;
  logic                   first_pos;
  logic                   gripper;
  logic                   gripper_cur;
  char_class_t            cls;
  logic                   scan_sok;
  logic [2:0]             scan_sidx;
  logic                   a_ok;
  logic [ANGLE_OUT_W-1:0] a_value;
  result_t                res_in;
  result_t                res_out;
  logic                   room;

  assign cmd_ready = room;
  assign step      = cmd_valid && cmd_ready;

  // Byte classification
  always_comb begin
    cls.is_digit = char_byte inside {[CH_ZERO:CH_NINE]};
    cls.is_colon = (char_byte == CH_COLON);
    cls.is_o     = (char_byte == CH_O);
    cls.is_c     = (char_byte == CH_C);
    cls.digit    = cls.is_digit ? char_byte[3:0] : 4'd0;
  end

  // Gripper mode is fixed by a 'G' at the head of the message
  assign gripper_cur = gripper || (first_pos && char_byte == CH_G);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pos <= 1'b1;
      gripper   <= 1'b0;
    end else if (step) begin
      first_pos <= last_byte;
      gripper   <= gripper_cur && !last_byte;
    end
  end

  scp_servo #(.SERVO_COUNT(SERVO_COUNT)) u_servo (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .last        (last_byte),
    .gripper     (gripper_cur),
    .cls         (cls),
    .servo_ok    (scan_sok),
    .servo_index (scan_sidx)
  );

  scp_angle #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_angle (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .last        (last_byte),
    .gripper     (gripper_cur),
    .cls         (cls),
    .angle_ok    (a_ok),
    .angle_value (a_value)
  );

  // Result assembly
  always_comb begin
    res_in.servo_index = gripper_cur ? GRIPPER_INDEX : scan_sidx;
    res_in.servo_ok    = gripper_cur || scan_sok;
    res_in.angle_value = a_value;
    res_in.angle_ok    = a_ok;
  end

  scp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step && last_byte),
    .push_data (res_in),
    .room      (room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_out)
  );

  assign servo_index = res_out.servo_index;
  assign servo_ok    = res_out.servo_ok;
  assign angle_value = res_out.angle_value;
  assign angle_ok    = res_out.angle_ok;

endmodule
